// ===== rtl/i2cmrt_pkg.sv =====
// shared types and constants for the i2c register transfer master
package i2cmrt_pkg;

   localparam int MAX_BYTES_DEF = 16;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_LOAD  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_HALF    = 2'd0,
      CSR_GUARD   = 2'd1,
      CSR_RSETUP  = 2'd2,
      CSR_TIMEOUT = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NACK_DEV = 2'd1,
      ST_NACK_REG = 2'd2,
      ST_NACK_DAT = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_TX0, PH_TX1, PH_TX2,
      PH_AK1, PH_AK2, PH_AK3, PH_AK4, PH_SP1, PH_SP2, PH_SP3, PH_SP4,
      PH_RX0, PH_RX1, PH_RX2, PH_RX3, PH_RX4, PH_RX5, PH_FIN
   } phase_type;

   typedef enum logic [2:0] {
      SG_DEV, SG_REG, SG_DATA, SG_MID, SG_RDEV, SG_RDATA, SG_END
   } stage_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] dev_addr;
      logic [7:0] reg_addr;
      logic [4:0] byte_count;
      logic [7:0] write_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_drive;
      logic [7:0] read_byte;
      logic [3:0] read_index;
      logic       read_valid;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

   // timing registers handed to the engine
   typedef struct packed {
      logic [15:0] half_phase_ticks;
      logic [15:0] guard_ticks;
      logic [15:0] read_setup_ticks;
      logic [13:0] ack_timeout;
   } csr_type;

endpackage

// ===== rtl/i2cmrt_queue.sv =====
// two-entry item queue between front and engine
module i2cmrt_queue import i2cmrt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_item,
   output logic    out_valid,
   input  logic    out_ready,
   output req_type out_item
);
   req_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // pointers and fill count
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (cnt_ff == $past(cnt_ff) - 2'd1))
      else $error("queue count lost on pop");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("queue count lost on push");
endmodule

// ===== rtl/i2cmrt_front.sv =====
// input stage: registers items and saturates the byte count
module i2cmrt_front import i2cmrt_pkg::*; #(
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    out_valid,
   input  logic    out_ready,
   output req_type out_item
);
   localparam logic [4:0] CAP = 5'(MAX_BYTES > 16 ? 16 : MAX_BYTES);
   logic    v_ff, v_in;
   req_type it_ff;
   req_type fixed;

   // classify: clamp count
   always_comb begin
      fixed = req_item;
      if (req_item.byte_count > CAP) begin
         fixed.byte_count = CAP;
      end
   end

   assign req_ready = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_item  = it_ff;
   assign v_in = (req_valid && req_ready) || (v_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         it_ff <= fixed;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (v_ff && !out_ready) |=> (v_ff && $stable(it_ff)))
      else $error("front stage dropped item");
   assert property (@(posedge clock) disable iff (reset)
      v_ff |-> (it_ff.byte_count <= CAP))
      else $error("front count not clamped");
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v_ff)
      else $error("front lost accepted item");
endmodule

// ===== rtl/i2cmrt_engine.sv =====
// bus engine: phase sequencer, counters, byte store and output register
module i2cmrt_engine import i2cmrt_pkg::*; #(
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);
   localparam int          SW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam logic [4:0] CAP = 5'(MAX_BYTES > 16 ? 16 : MAX_BYTES);

   phase_type   ph_ff, ph_in;
   stage_type   sg_ff, sg_in;
   logic [3:0]  bc_ff, bc_in;
   logic [7:0]  sh_ff, sh_in;
   logic [4:0]  bi_ff, bi_in;
   logic [15:0] wc_ff, wc_in;
   logic [13:0] pc_ff, pc_in;
   logic [4:0]  lc_ff, lc_in;
   logic [1:0]  ss_ff, ss_in;
   logic [7:0]  dev_ff, dev_in, reg_ff, reg_in;
   logic        rd_ff, rd_in, ak_ff, ak_in;
   logic        scl_ff, scl_in, sda_ff, sda_in_r, drv_ff, drv_in;
   logic [7:0]  store_ff [MAX_BYTES];
   logic        ov_ff, ov_in;
   rsp_type     o_ff, o_in;
   logic        take, st_we;
   logic [SW-1:0] st_wa;
   logic [7:0]  nxt_byte;
   logic [13:0] tmo, pinc;
   logic [4:0]  bdec;

   assign in_ready  = !ov_ff || rsp_ready;
   assign take      = in_valid && in_ready;
   assign rsp_valid = ov_ff;
   assign rsp_item  = o_ff;
   assign tmo  = (csr.ack_timeout == 14'd0) ? 14'd1 : csr.ack_timeout;
   assign pinc = pc_ff + 14'd1;

   // next data byte: entry at index byte_index-1 after optional decrement
   always_comb begin
      bdec = bi_ff - 5'd1;
      if (ph_ff == PH_AK4 && sg_ff == SG_DATA && bi_ff > 5'd0) begin
         bdec = bi_ff - 5'd2;
      end
      nxt_byte = store_ff[SW'(bdec)];
   end

   // phase sequencer
   always_comb begin
      ph_in = ph_ff; sg_in = sg_ff; bc_in = bc_ff; sh_in = sh_ff; bi_in = bi_ff;
      wc_in = wc_ff; pc_in = pc_ff; lc_in = lc_ff; ss_in = ss_ff;
      dev_in = dev_ff; reg_in = reg_ff; rd_in = rd_ff; ak_in = ak_ff;
      scl_in = scl_ff; sda_in_r = sda_ff; drv_in = drv_ff;
      st_we = 1'b0; st_wa = SW'(lc_ff);
      o_in = '0;
      if (take) begin
         if (in_item.op == OP_TICK) begin
            if (ph_ff != PH_IDLE) begin
               if (wc_ff != 16'd0) begin
                  wc_in = wc_ff - 16'd1;
               end else begin
                  unique case (ph_ff)
                     PH_ST1: begin
                        sda_in_r = 1'b1; drv_in = 1'b1;
                        wc_in = csr.half_phase_ticks; ph_in = PH_ST2;
                     end
                     PH_ST2: begin
                        scl_in = 1'b1; wc_in = csr.half_phase_ticks; ph_in = PH_ST3;
                     end
                     PH_ST3: begin
                        sda_in_r = 1'b0; wc_in = csr.half_phase_ticks; ph_in = PH_ST4;
                     end
                     PH_ST4: begin
                        scl_in = 1'b0; wc_in = csr.guard_ticks; ph_in = PH_TX0;
                        if (sg_ff == SG_RDEV) begin
                           sh_in = dev_ff | 8'h01;
                        end else begin
                           sh_in = dev_ff; sg_in = SG_DEV;
                        end
                     end
                     PH_TX0: begin
                        scl_in = 1'b0; bc_in = 4'd0;
                        wc_in = csr.half_phase_ticks; ph_in = PH_TX1;
                     end
                     PH_TX1: begin
                        scl_in = 1'b0; drv_in = 1'b1; sda_in_r = sh_ff[7];
                        sh_in = {sh_ff[6:0], 1'b0};
                        wc_in = csr.half_phase_ticks; ph_in = PH_TX2;
                     end
                     PH_TX2: begin
                        scl_in = 1'b1; wc_in = csr.half_phase_ticks;
                        bc_in = bc_ff + 4'd1;
                        ph_in = (bc_ff + 4'd1 < 4'd8) ? PH_TX1 : PH_AK1;
                     end
                     PH_AK1: begin
                        scl_in = 1'b0; drv_in = 1'b0;
                        wc_in = csr.half_phase_ticks; ph_in = PH_AK2;
                     end
                     PH_AK2: begin
                        scl_in = 1'b1; pc_in = 14'd0; wc_in = 16'd0; ph_in = PH_AK3;
                     end
                     PH_AK3: begin
                        if (!in_item.sda_in) begin
                           ak_in = 1'b1; wc_in = 16'd1; ph_in = PH_AK4;
                        end else begin
                           pc_in = pinc;
                           if (pinc >= tmo) begin
                              ak_in = 1'b0; wc_in = 16'd1; ph_in = PH_AK4;
                           end
                        end
                     end
                     PH_AK4: begin
                        scl_in = 1'b0; drv_in = 1'b1; sda_in_r = 1'b0;
                        wc_in = csr.guard_ticks;
                        unique case (sg_ff)
                           SG_DEV: begin
                              if (ak_ff) begin
                                 sh_in = reg_ff; sg_in = SG_REG; ph_in = PH_TX0;
                              end else begin
                                 ss_in = ST_NACK_DEV; sg_in = SG_END; ph_in = PH_SP1;
                              end
                           end
                           SG_REG: begin
                              if (!ak_ff) begin
                                 ss_in = ST_NACK_REG; sg_in = SG_END; ph_in = PH_SP1;
                              end else if (rd_ff) begin
                                 sg_in = SG_MID; ph_in = PH_SP1;
                              end else if (bi_ff > 5'd0) begin
                                 sh_in = nxt_byte; sg_in = SG_DATA; ph_in = PH_TX0;
                              end else begin
                                 sg_in = SG_END; ph_in = PH_SP1;
                              end
                           end
                           SG_DATA: begin
                              if (!ak_ff) begin
                                 ss_in = ST_NACK_DAT; sg_in = SG_END; ph_in = PH_SP1;
                              end else begin
                                 if (bi_ff > 5'd0) bi_in = bi_ff - 5'd1;
                                 if (bi_ff > 5'd1) begin
                                    sh_in = nxt_byte; ph_in = PH_TX0;
                                 end else begin
                                    sg_in = SG_END; ph_in = PH_SP1;
                                 end
                              end
                           end
                           default: begin
                              if (bi_ff > 5'd0) begin
                                 sg_in = SG_RDATA; ph_in = PH_RX0;
                              end else begin
                                 sg_in = SG_END; ph_in = PH_SP1;
                              end
                           end
                        endcase
                     end
                     PH_SP1: begin
                        scl_in = 1'b0; sda_in_r = 1'b0; drv_in = 1'b1;
                        wc_in = csr.half_phase_ticks; ph_in = PH_SP2;
                     end
                     PH_SP2: begin
                        scl_in = 1'b1; wc_in = csr.half_phase_ticks; ph_in = PH_SP3;
                     end
                     PH_SP3: begin
                        sda_in_r = 1'b1; wc_in = csr.half_phase_ticks; ph_in = PH_SP4;
                     end
                     PH_SP4: begin
                        wc_in = csr.guard_ticks;
                        if (sg_ff == SG_MID) begin
                           sg_in = SG_RDEV; ph_in = PH_ST1;
                        end else begin
                           ph_in = PH_FIN;
                        end
                     end
                     PH_RX0: begin
                        drv_in = 1'b0; sda_in_r = 1'b1; scl_in = 1'b0;
                        bc_in = 4'd0; sh_in = 8'd0;
                        wc_in = csr.read_setup_ticks; ph_in = PH_RX1;
                     end
                     PH_RX1: begin
                        scl_in = 1'b1; wc_in = csr.half_phase_ticks; ph_in = PH_RX2;
                     end
                     PH_RX2: begin
                        sh_in = {sh_ff[6:0], in_item.sda_in};
                        scl_in = 1'b0; wc_in = csr.half_phase_ticks;
                        bc_in = bc_ff + 4'd1;
                        ph_in = (bc_ff + 4'd1 < 4'd8) ? PH_RX1 : PH_RX3;
                     end
                     PH_RX3: begin
                        o_in.read_valid = 1'b1; o_in.read_byte = sh_ff;
                        o_in.read_index = 4'(bi_ff - 5'd1);
                        scl_in = 1'b0; drv_in = 1'b1;
                        sda_in_r = (bi_ff <= 5'd1);
                        wc_in = csr.half_phase_ticks; ph_in = PH_RX4;
                     end
                     PH_RX4: begin
                        scl_in = 1'b1; wc_in = csr.half_phase_ticks; ph_in = PH_RX5;
                     end
                     PH_RX5: begin
                        scl_in = 1'b0; wc_in = csr.guard_ticks;
                        if (bi_ff > 5'd0) bi_in = bi_ff - 5'd1;
                        if (bi_ff > 5'd1) begin
                           ph_in = PH_RX0;
                        end else begin
                           sg_in = SG_END; ph_in = PH_SP1;
                        end
                     end
                     PH_FIN: begin
                        o_in.done_res = 1'b1; ph_in = PH_IDLE;
                     end
                     default: ph_in = PH_IDLE;
                  endcase
               end
            end
         end else if (ph_ff == PH_IDLE) begin
            if (in_item.op == OP_LOAD) begin
               if (lc_ff < CAP) begin
                  st_we = 1'b1; lc_in = lc_ff + 5'd1;
               end
            end else begin
               rd_in = (in_item.op == OP_READ);
               dev_in = in_item.dev_addr; reg_in = in_item.reg_addr;
               bi_in = in_item.byte_count; ss_in = ST_OK; sg_in = SG_DEV;
               wc_in = 16'd0; ph_in = PH_ST1;
               if (in_item.op == OP_WRITE) lc_in = 5'd0;
            end
         end
         o_in.scl_out = scl_in; o_in.sda_out = sda_in_r; o_in.sda_drive = drv_in;
         o_in.busy_res = (ph_in != PH_IDLE); o_in.status = ss_in;
      end
      ov_in = take || (ov_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE; sg_ff <= SG_END; bc_ff <= '0; sh_ff <= '0; bi_ff <= '0;
         wc_ff <= '0; pc_ff <= '0; lc_ff <= '0; ss_ff <= '0;
         dev_ff <= '0; reg_ff <= '0; rd_ff <= 1'b0; ak_ff <= 1'b0;
         scl_ff <= 1'b1; sda_ff <= 1'b1; drv_ff <= 1'b1; ov_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in; sg_ff <= sg_in; bc_ff <= bc_in; sh_ff <= sh_in; bi_ff <= bi_in;
         wc_ff <= wc_in; pc_ff <= pc_in; lc_ff <= lc_in; ss_ff <= ss_in;
         dev_ff <= dev_in; reg_ff <= reg_in; rd_ff <= rd_in; ak_ff <= ak_in;
         scl_ff <= scl_in; sda_ff <= sda_in_r; drv_ff <= drv_in; ov_ff <= ov_in;
      end
   end

   // result register and byte store
   always_ff @(posedge clock) begin
      if (take) o_ff <= o_in;
      if (st_we) store_ff[st_wa] <= in_item.write_byte;
   end

   assert property (@(posedge clock) disable iff (reset) lc_ff <= CAP)
      else $error("load count past store depth");
   assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !rsp_ready) |=> $stable(o_ff))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (ph_ff == PH_AK3) |-> (scl_ff && !drv_ff))
      else $error("acknowledge polled without scl high and sda released");
   assert property (@(posedge clock) disable iff (reset)
      (ph_ff == PH_RX1 || ph_ff == PH_RX2) |-> !drv_ff)
      else $error("driving sda while receiving");
endmodule

// ===== rtl/i2c_master_register_transfer.sv =====
// top level of the i2c register transfer master
//  channel | ports                         | role
//  req     | req_valid/req_ready/req_item  | one tick or command per item
//  rsp     | rsp_valid/rsp_ready/rsp_item  | pin levels and status per item
//  csr     | csr_we/csr_index/csr_wdata    | timing register writes
// one item per cycle sustained while rsp_ready is high; each item passes a
// front register, a two-entry queue and the engine's result register.
// synchronous reset idles the bus with scl and sda high and driven.
// a stalled rsp side fills the result register, then the queue, then front.
module i2c_master_register_transfer import i2cmrt_pkg::*; #(
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_item,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   csr_type csr_ff, csr_in;
   logic    f_valid, f_ready, q_valid, q_ready;
   req_type f_item, q_item;

   // timing registers
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_HALF:    csr_in.half_phase_ticks = csr_wdata;
            CSR_GUARD:   csr_in.guard_ticks = csr_wdata;
            CSR_RSETUP:  csr_in.read_setup_ticks = csr_wdata;
            CSR_TIMEOUT: csr_in.ack_timeout = csr_wdata[13:0];
            default:     csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{16'd5, 16'd500, 16'd30, 14'd10000};
      end else begin
         csr_ff <= csr_in;
      end
   end

   i2cmrt_front #(.MAX_BYTES(MAX_BYTES)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_item,
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
   );

   i2cmrt_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   i2cmrt_engine #(.MAX_BYTES(MAX_BYTES)) u_engine (
      .clock, .reset, .csr(csr_ff), .in_valid(q_valid), .in_ready(q_ready),
      .in_item(q_item), .rsp_valid, .rsp_ready, .rsp_item
   );
endmodule
